// ----- src/lfa_pkg.sv -----
// ============================================================================
// lfa_pkg
// Shared types and constants for the lowest-free identifier allocator.
// ============================================================================
package lfa_pkg;

    localparam int LFA_ID_COUNT  = 1024;  // default number of identifiers
    localparam int LFA_WORD_W    = 64;    // bits per bitmap word
    localparam int LFA_ID_W      = 10;    // width of the identifier fields
    localparam int LFA_FIELD_LIM = 1024;  // identifiers that fit the id field
    localparam int LFA_CMP_W     = 17;    // compare width, holds 65536

    // result status codes
    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NONE_FREE = 2'd1,
        STATUS_RESERVED  = 2'd2
    } status_t;

    // request kinds carried on tuser
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_RESP
    } state_t;

    // lowest-clear-bit search result for one bitmap word
    typedef struct packed {
        logic                  hit;      // word has a clear bit
        logic [5:0]            bit_pos;  // lowest clear bit
        logic [LFA_WORD_W-1:0] word;     // word as read
    } find_res_t;

endpackage

// ----- src/lfa_bitmap_mem.sv -----
// ============================================================================
// lfa_bitmap_mem
// Bitmap word store: one write port, one read port, registered read data.
// ============================================================================
module lfa_bitmap_mem
    import lfa_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [LFA_WORD_W-1:0] wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output logic [LFA_WORD_W-1:0] rdata
);

    logic [LFA_WORD_W-1:0] mem [0:DEPTH-1];
    logic [LFA_WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/lfa_find.sv -----
// ============================================================================
// lfa_find
// Two-level lowest-clear-bit search over one bitmap word; per-byte results are registered.
// ============================================================================
module lfa_find
    import lfa_pkg::*;
(
    input  logic                  aclk,
    input  logic [LFA_WORD_W-1:0] word_in,
    output find_res_t             res
);

    localparam int GROUPS = LFA_WORD_W / 8;

    logic [GROUPS-1:0]     any_next;
    logic [GROUPS-1:0]     any_reg;
    logic [2:0]            low_next [0:GROUPS-1];
    logic [2:0]            low_reg  [0:GROUPS-1];
    logic [LFA_WORD_W-1:0] word_reg;
    logic [LFA_WORD_W-1:0] free_bits;
    logic [2:0]            sel;

    assign free_bits = ~word_in;

    // per byte: any clear bit, and the lowest one
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            any_next[g] = |free_bits[g*8 +: 8];
            low_next[g] = 3'd0;
            for (int b = 7; b >= 0; b--) begin
                if (free_bits[g*8 + b]) begin
                    low_next[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        any_reg  <= any_next;
        low_reg  <= low_next;
        word_reg <= word_in;
    end

    // pick the lowest byte that has a clear bit
    always_comb begin
        sel = 3'd0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (any_reg[g]) begin
                sel = 3'(g);
            end
        end
        res.hit     = |any_reg;
        res.bit_pos = {sel, low_reg[sel]};
        res.word    = word_reg;
    end

endmodule

// ----- src/lowest_free_id_allocator.sv -----
// ============================================================================
// lowest_free_id_allocator
// Bitmap identifier allocator: grants the lowest free identifier, frees one.
// ============================================================================
// Sequence: an allocate reads bitmap words upward from word 0 through the memory
//   read and search registers until a word with a clear bit or the last scanned
//   word comes back; a free reads its word, clears the bit and writes it back;
//   a free of id 0 or of an id out of range skips the bitmap.
// Throughput: one request in flight; the scan reads one bitmap word per cycle.
// Reset: aresetn low clears control; afterwards a clearing pass writes every
//   bitmap word (id 0 marked in use) before s_tready rises.
// ============================================================================
module lowest_free_id_allocator
    import lfa_pkg::*;
#(
    parameter int ID_COUNT = LFA_ID_COUNT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] free_id, [15:10] zero
    input  logic [0:0]  s_tuser,   // [0] kind (0 allocate, 1 free)
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [11:2] granted_id, [15:12] zero
);

    localparam int WORD_COUNT  = (ID_COUNT + LFA_WORD_W - 1) / LFA_WORD_W;
    localparam int ADDR_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int IDX_W       = ADDR_W + 6;
    localparam int ALLOC_LIMIT = (ID_COUNT < LFA_FIELD_LIM) ? ID_COUNT : LFA_FIELD_LIM;
    localparam int ALLOC_WORDS = (ALLOC_LIMIT + LFA_WORD_W - 1) / LFA_WORD_W;
    localparam logic [ADDR_W-1:0] LAST_WORD  = ADDR_W'(WORD_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_SCAN  = ADDR_W'(ALLOC_WORDS - 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [ADDR_W-1:0]      scan_addr_reg;
    logic                   issue_done_reg;
    logic                   rd_vld_reg, f_vld_reg;
    logic [ADDR_W-1:0]      rd_idx_reg, f_idx_reg;
    logic                   rd_last_reg, f_last_reg;
    logic [LFA_ID_W-1:0]    fid_reg;
    status_t                res_status_reg, res_status_next;
    logic [LFA_ID_W-1:0]    res_id_reg, res_id_next;
    logic                   m_valid_reg;
    logic [15:0]            m_data_reg;

    // memory and search
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
    logic [LFA_WORD_W-1:0]  mem_wdata, mem_rdata;
    find_res_t              fres;

    // control
    logic                   s_accept;
    logic                   req_kind;
    logic [LFA_ID_W-1:0]    req_fid;
    logic                   req_fid_zero, req_fid_in_range;
    logic [ADDR_W-1:0]      free_addr;
    logic [IDX_W-1:0]       id_full;
    logic                   id_ok;
    logic                   scan_stop;
    logic                   issue;
    logic                   res_load;
    logic                   m_load;

    lfa_bitmap_mem #(
        .DEPTH  (WORD_COUNT),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lfa_find u_find (
        .aclk    (aclk),
        .word_in (mem_rdata),
        .res     (fres)
    );

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign s_accept         = s_tvalid && s_tready;
    assign req_kind         = s_tuser[0];
    assign req_fid          = s_tdata[LFA_ID_W-1:0];
    assign req_fid_zero     = (req_fid == '0);
    assign req_fid_in_range = (LFA_CMP_W'(req_fid) < LFA_CMP_W'(ID_COUNT));
    assign free_addr        = ADDR_W'(fid_reg >> 6);

    // scan decision: a word with a clear bit, or the last word came back full
    assign id_full   = {f_idx_reg, fres.bit_pos};
    assign id_ok     = (LFA_CMP_W'(id_full) < LFA_CMP_W'(ALLOC_LIMIT));
    assign scan_stop = (state_reg == ST_SCAN) && f_vld_reg && (fres.hit || f_last_reg);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    if (req_kind == KIND_ALLOC) begin
                        state_next = ST_SCAN;
                    end else if (req_fid_zero || !req_fid_in_range) begin
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_FREE_RD;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_stop) begin
                    state_next = ST_RESP;
                end
            end
            ST_FREE_RD: state_next = ST_FREE_WR;
            ST_FREE_WR: state_next = ST_RESP;
            ST_RESP: begin
                if (m_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb begin
        s_tready        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = free_addr;
        mem_wdata       = '0;
        mem_raddr       = free_addr;
        issue           = 1'b0;
        res_load        = 1'b0;
        res_status_next = STATUS_DONE;
        res_id_next     = '0;
        m_load          = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                // wipe one word per cycle, keep id 0 reserved
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = (clr_addr_reg == '0) ? LFA_WORD_W'(1) : '0;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_accept && req_kind == KIND_FREE) begin
                    if (req_fid_zero) begin
                        res_load        = 1'b1;
                        res_status_next = STATUS_RESERVED;
                    end else if (!req_fid_in_range) begin
                        res_load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                mem_raddr = scan_addr_reg;
                issue     = !issue_done_reg && !scan_stop;
                if (scan_stop) begin
                    res_load = 1'b1;
                    if (fres.hit && id_ok) begin
                        // mark the granted id in use
                        mem_we      = 1'b1;
                        mem_waddr   = f_idx_reg;
                        mem_wdata   = fres.word | (LFA_WORD_W'(1) << fres.bit_pos);
                        res_id_next = LFA_ID_W'(id_full);
                    end else begin
                        res_status_next = STATUS_NONE_FREE;
                    end
                end
            end
            ST_FREE_RD: begin
                mem_raddr = free_addr;
            end
            ST_FREE_WR: begin
                // read data is back: clear the bit and write the word back
                mem_we    = 1'b1;
                mem_wdata = mem_rdata & ~(LFA_WORD_W'(1) << fid_reg[5:0]);
                res_load  = 1'b1;
            end
            ST_RESP: begin
                m_load = !m_valid_reg || m_tready;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            scan_addr_reg  <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            f_vld_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            // restart the scan on every accepted request
            if (s_accept) begin
                scan_addr_reg  <= '0;
                issue_done_reg <= 1'b0;
            end else if (issue) begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
                if (scan_addr_reg == LAST_SCAN) begin
                    issue_done_reg <= 1'b1;
                end
            end
            // drop words still in flight once the scan has decided
            rd_vld_reg <= issue;
            f_vld_reg  <= rd_vld_reg && !scan_stop && (state_reg == ST_SCAN);
            // output slot: load the pending result, release on transfer
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg  <= scan_addr_reg;
        rd_last_reg <= (scan_addr_reg == LAST_SCAN);
        f_idx_reg   <= rd_idx_reg;
        f_last_reg  <= rd_last_reg;
        if (s_accept) begin
            fid_reg <= req_fid;
        end
        if (res_load) begin
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
        end
        if (m_load) begin
            m_data_reg <= {4'd0, res_id_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a nonzero granted id only comes with a successful allocate
    a_grant_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[11:2] != '0) |-> (m_tdata[1:0] == STATUS_DONE))
        else $error("granted id with non-done status");

    // a scan only writes the bitmap for a searched word that had a clear bit
    a_scan_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == ST_SCAN) |-> (f_vld_reg && fres.hit))
        else $error("bitmap write during scan without a hit");

    // word reads in flight always come from an active scan
    a_read_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> ($past(state_reg) == ST_SCAN))
        else $error("scan read issued outside of a scan");

endmodule

// ----- bench/lowest_free_id_allocator_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lowest_free_id_allocator_test
// Self-checking bench for the bitmap identifier allocator. A bit-level model
// of the in-use map predicts every result. Directed requests cover the
// reserved id, double frees and the extremes of free_id. Biased random runs
// then fill the map to exhaustion and drain it again. Both channels idle at
// random, and one phase holds the result side off for a long stretch.
// ============================================================================
module lowest_free_id_allocator_test;
    import lfa_pkg::*;

    localparam int ID_COUNT     = LFA_ID_COUNT;
    localparam int WORDS        = (ID_COUNT + LFA_WORD_W - 1) / LFA_WORD_W;
    // grants never reach past the width of the granted_id field
    localparam int GRANT_LIMIT  = (ID_COUNT < LFA_FIELD_LIM) ? ID_COUNT : LFA_FIELD_LIM;
    localparam int CLK_PERIOD   = 20;
    localparam int IDLE_PCT     = 32;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 40;
    localparam longint TIMEOUT_NS = 20_000_000;

    typedef struct {
        status_t             status;
        logic [LFA_ID_W-1:0] granted_id;
    } alloc_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [9:0] free_id, [15:10] zero
    logic [0:0]  s_tuser;   // [0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [1:0] status, [11:2] granted_id, [15:12] zero

    // model of the in-use bitmap and its population below GRANT_LIMIT
    logic [LFA_WORD_W-1:0] id_map [WORDS];
    int                    ids_in_use;

    // results still owed by the block, oldest first
    alloc_result_t pending_results[$];

    int error_count  = 0;
    bit steady       = 1'b0;   // no idling on either side while set
    bit hold_request = 1'b0;   // result side holds off while set

    lowest_free_id_allocator #(
        .ID_COUNT(ID_COUNT)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Allocation model
    // ------------------------------------------------------------------------
    function automatic void clear_id_map();
        for (int w = 0; w < WORDS; w++) begin
            id_map[w] = '0;
        end
        // id 0 is reserved from reset on
        id_map[0][0] = 1'b1;
        ids_in_use   = 1;
    endfunction

    // Apply one request to the map and return the result it must produce.
    function automatic alloc_result_t predict_request(logic kind, logic [LFA_ID_W-1:0] fid);
        alloc_result_t r;
        bit            found;
        r.status     = STATUS_DONE;
        r.granted_id = '0;
        found        = 1'b0;
        if (kind == KIND_ALLOC) begin
            // lowest clear bit wins
            for (int id = 0; id < GRANT_LIMIT && !found; id++) begin
                if (!id_map[id / LFA_WORD_W][id % LFA_WORD_W]) begin
                    found = 1'b1;
                    id_map[id / LFA_WORD_W][id % LFA_WORD_W] = 1'b1;
                    r.granted_id = id[LFA_ID_W-1:0];
                    ids_in_use++;
                end
            end
            if (!found) begin
                r.status = STATUS_NONE_FREE;
            end
        end else if (fid == '0) begin
            // reserved id: map untouched
            r.status = STATUS_RESERVED;
        end else if (int'(fid) < ID_COUNT) begin
            // freeing a free id is harmless
            if (id_map[fid / LFA_WORD_W][fid % LFA_WORD_W]) begin
                id_map[fid / LFA_WORD_W][fid % LFA_WORD_W] = 1'b0;
                if (int'(fid) < GRANT_LIMIT) begin
                    ids_in_use--;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Offer one request, hold it until the transfer, then book its result.
    task automatic send_request(input logic kind, input logic [LFA_ID_W-1:0] fid);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, fid};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_results.push_back(predict_request(kind, fid));
    endtask

    task automatic idle_bus();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Free target: some reserved, many low ids to punch holes near the bottom.
    function automatic logic [LFA_ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return '0;
        end else if (r < 50) begin
            return LFA_ID_W'($urandom_range(1, 127));
        end
        return LFA_ID_W'($urandom_range(1, 1023));
    endfunction

    // Random mix; the id field of an allocate carries noise.
    task automatic send_random(int free_pct);
        if ($urandom_range(0, 99) < free_pct) begin
            send_request(KIND_FREE, pick_id());
        end else begin
            send_request(KIND_ALLOC, LFA_ID_W'($urandom_range(0, 1023)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_count;
        hold_count = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                // hold off and count the stall
                m_tready <= 1'b0;
                hold_count++;
                if (hold_count >= HOLD_CYCLES) begin
                    hold_count   = 0;
                    hold_request = 1'b0;
                end
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : check_results
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    report_mismatch("status", m_tdata[1:0], want.status);
                end
                if (m_tdata[11:2] !== want.granted_id) begin
                    report_mismatch("granted_id", m_tdata[11:2], want.granted_id);
                end
                if (m_tdata[15:12] !== 4'b0) begin
                    report_mismatch("tdata pad", m_tdata[15:12], 0);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reserved id, double free, both ends of free_id, id field ignored on allocate.
    task automatic test_reserved_and_edges();
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_ALLOC, 10'h3FF);
        send_request(KIND_FREE,  10'd0);
        send_request(KIND_FREE,  10'd1);
        send_request(KIND_FREE,  10'd1);
        send_request(KIND_ALLOC, 10'h2AA);
        send_request(KIND_FREE,  10'h3FF);
        send_request(KIND_FREE,  10'd512);
        send_request(KIND_ALLOC, 10'h155);
        send_request(KIND_FREE,  10'd2);
        send_request(KIND_FREE,  10'd3);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_FREE,  10'h2AA);
        send_request(KIND_FREE,  10'h155);
        send_request(KIND_ALLOC, 10'h3FF);
        send_request(KIND_ALLOC, 10'd0);
    endtask

    // Mostly allocates until the map runs out, then probe the full map.
    task automatic test_fill_to_exhaustion();
        int n;
        n = 0;
        while (ids_in_use < GRANT_LIMIT) begin
            // long stretch with no idling at the start
            steady = (n < 300);
            send_random(3);
            n++;
        end
        steady = 1'b0;
        repeat (4) send_request(KIND_ALLOC, LFA_ID_W'($urandom_range(0, 1023)));
        send_request(KIND_FREE,  10'd0);
        send_request(KIND_ALLOC, 10'd0);
        // reopen the top id and grab it back
        send_request(KIND_FREE,  10'h3FF);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_FREE,  10'd700);
        send_request(KIND_FREE,  10'd700);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_ALLOC, 10'd0);
    endtask

    // Result side holds off while requests keep coming; input must stall.
    task automatic test_output_stall();
        hold_request = 1'b1;
        repeat (20) send_random(50);
        while (hold_request) begin
            @(posedge aclk);
        end
    endtask

    // Sender goes quiet until every result is back, then resumes.
    task automatic test_sender_pause();
        repeat (3) begin
            repeat (6) send_random(50);
            idle_bus();
            while (pending_results.size() != 0) begin
                @(posedge aclk);
            end
        end
    endtask

    task automatic test_random_mix(int count, int free_pct);
        repeat (count) send_random(free_pct);
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        clear_id_map();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reserved_and_edges();
        test_fill_to_exhaustion();
        test_output_stall();
        test_sender_pause();
        test_random_mix(550, 65);
        test_random_mix(150, 50);

        idle_bus();
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        // let any stray result surface
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[%0t] timeout, %0d results pending", $time, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
